### design/image_convolution_filter_unit_assert.svh
// Assertion macros used by the convolution filter top level.
`ifndef IMAGE_CONVOLUTION_FILTER_UNIT_ASSERT_SVH
`define IMAGE_CONVOLUTION_FILTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICF_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("convolution filter check failed");

// Consequent must hold in the cycle after the antecedent.
`define ICF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("convolution filter sequence check failed");

`endif

### design/icf_pkg.sv
// Types, constants and kernel table of the convolution filter.
`timescale 1ns / 1ps

package icf_pkg;

  localparam int W_MAX = 2048;
  localparam int H_MAX = 2048;
  localparam int K_MAX = 5;

  // pixel history ring: must span the full 5x5 window plus the lag
  localparam int RAM_AW    = $clog2((K_MAX - 1) * W_MAX + 2 * K_MAX);
  localparam int RAM_DEPTH = 1 << RAM_AW;

  // register addresses (word index)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  // kernel select codes
  localparam logic [2:0] KSEL_BLUR3   = 3'd0;
  localparam logic [2:0] KSEL_GAUSS5  = 3'd1;
  localparam logic [2:0] KSEL_SOBELX  = 3'd2;
  localparam logic [2:0] KSEL_SOBELY  = 3'd3;
  localparam logic [2:0] KSEL_SHARPEN = 3'd4;
  localparam logic [2:0] KSEL_EMBOSS  = 3'd5;
  localparam logic [2:0] KSEL_MAG     = 3'd6;

  // reciprocal division constants, quotient = (x * R) >> DIV_SHIFT, then one fix-up
  localparam int          DIV_SHIFT = 24;
  localparam logic [20:0] RECIP_9   = 21'd1864135;
  localparam logic [20:0] RECIP_273 = 21'd61455;
  localparam logic [8:0]  DIV_9     = 9'd9;
  localparam logic [8:0]  DIV_273   = 9'd273;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_in;
  } icf_req_t;

  typedef struct packed {
    logic signed [11:0] filtered_value;
    logic [7:0]         clamped_byte;
    logic [10:0]        out_row;
    logic [10:0]        out_col;
    logic               frame_last;
  } icf_res_t;

  localparam logic signed [6:0] KERN_TAB [6][25] = '{
    '{ 0, 0, 0, 0, 0,   0, 1, 1, 1, 0,   0, 1, 1, 1, 0,   0, 1, 1, 1, 0,   0, 0, 0, 0, 0 },
    '{ 1, 4, 7, 4, 1,   4, 16, 26, 16, 4,   7, 26, 41, 26, 7,
       4, 16, 26, 16, 4,   1, 4, 7, 4, 1 },
    '{ 0, 0, 0, 0, 0,   0, -1, 0, 1, 0,   0, -2, 0, 2, 0,   0, -1, 0, 1, 0,   0, 0, 0, 0, 0 },
    '{ 0, 0, 0, 0, 0,   0, -1, -2, -1, 0,   0, 0, 0, 0, 0,   0, 1, 2, 1, 0,   0, 0, 0, 0, 0 },
    '{ 0, 0, 0, 0, 0,   0, 0, -1, 0, 0,   0, -1, 5, -1, 0,   0, 0, -1, 0, 0,   0, 0, 0, 0, 0 },
    '{ 0, 0, 0, 0, 0,   0, -2, -1, 0, 0,   0, -1, 1, 1, 0,   0, 0, 1, 2, 0,   0, 0, 0, 0, 0 }
  };

  // weight at window row i, column j (0..4); codes above KSEL_EMBOSS weigh zero
  function automatic logic signed [6:0] kern_weight(input logic [2:0] sel,
                                                    input logic [2:0] i,
                                                    input logic [2:0] j);
    logic [4:0] idx;
    idx = {i, 2'b00} + {2'b00, i} + {2'b00, j};
    if (sel > KSEL_EMBOSS) return 7'sd0;
    return KERN_TAB[sel][idx];
  endfunction

endpackage

### design/icf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module icf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/image_convolution_filter_unit.sv
// Top level: streaming zero-padded 2-D convolution with Sobel magnitude.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  req     | in        | req_valid / req_stall  | icf_req_t (type, pixel)
//  res     | out       | res_valid / res_stall  | icf_res_t (value, byte, pos)
//  apb     | in        | psel/penable/pready    | 3 registers at 0x0/0x4/0x8
//
// Sequence: an item that yields no result is taken without a window walk. An item
//   with a result walks its 3x3 or 5x5 window through the read loop on the
//   single pixel RAM port, then divides (blur/gauss), passes straight on (plain
//   kernels) or takes the magnitude (squares, 11-step root, rounding), and then
//   loads the output register.
// Reset clears counters, state and registers; the pixel RAM is not cleared.
// A full output register that is stalled holds the final stage; new items
//   are still taken while a finished result waits. In the cycle after a register
//   write the input is stalled while geometry products settle.
`timescale 1ns / 1ps
`include "image_convolution_filter_unit_assert.svh"

module image_convolution_filter_unit
  import icf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  icf_req_t    req_item,
  output logic        res_valid,
  input  logic        res_stall,
  output icf_res_t    res_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_TAP  = 10'b0000000010,
    S_TAIL = 10'b0000000100,
    S_DIV1 = 10'b0000001000,
    S_DIV2 = 10'b0000010000,
    S_SQ   = 10'b0000100000,
    S_SUM  = 10'b0001000000,
    S_ROOT = 10'b0010000000,
    S_RND  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // ---------------- configuration ----------------
  logic [11:0] cfg_width, cfg_height;
  logic [2:0]  cfg_kernel;
  logic        cfg_wr, cfg_hold;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= 12'd1024;
      cfg_height <= 12'd1024;
      cfg_kernel <= KSEL_BLUR3;
      cfg_hold   <= 1'b0;
    end else begin
      cfg_hold <= cfg_wr;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_WIDTH:  cfg_width  <= pwdata[11:0];
          REG_HEIGHT: cfg_height <= pwdata[11:0];
          REG_KERNEL: cfg_kernel <= pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, cfg_width};
      REG_HEIGHT: prdata = {20'd0, cfg_height};
      REG_KERNEL: prdata = {29'd0, cfg_kernel};
      default:    prdata = 32'd0;
    endcase
  end

  // cfg_wr on an unused address restarts nothing
  logic cfg_restart;
  assign cfg_restart = cfg_wr && (paddr[3:2] != 2'd3);

  // effective geometry, clamped to 1..max
  logic [11:0] w_eff, h_eff;
  logic        rad2;
  logic [1:0]  rad;
  assign w_eff = (cfg_width == 12'd0) ? 12'd1
               : ((cfg_width > 12'(W_MAX)) ? 12'(W_MAX) : cfg_width);
  assign h_eff = (cfg_height == 12'd0) ? 12'd1
               : ((cfg_height > 12'(H_MAX)) ? 12'(H_MAX) : cfg_height);
  assign rad2  = (cfg_kernel == KSEL_GAUSS5);
  assign rad   = rad2 ? 2'd2 : 2'd1;

  // registered geometry products: frame size, lag, ring row step
  logic [22:0]        total;
  logic [12:0]        lag;
  logic [RAM_AW-1:0]  row_skip;

  always_ff @(posedge clk) begin
    total    <= 23'(w_eff * h_eff);
    lag      <= rad2 ? (13'({w_eff, 1'b0}) + 13'd2) : (13'(w_eff) + 13'd1);
    row_skip <= RAM_AW'(w_eff) - (rad2 ? RAM_AW'(4) : RAM_AW'(2));
  end

  // ---------------- item acceptance ----------------
  logic [22:0] vin;
  logic [10:0] out_row, out_col;
  logic        req_acc;
  logic        is_drain, past_end, drop, new_frame, past_lag, tail_done, produce, last;
  logic [22:0] vin_eff, q;
  logic [10:0] base_row, base_col;

  assign req_stall = (state != S_IDLE) || cfg_hold;
  assign req_acc   = req_valid && !req_stall;

  assign is_drain  = req_item.req_type;
  assign past_end  = (vin >= total);
  assign drop      = is_drain && !past_end;
  assign new_frame = !is_drain && past_end;
  assign vin_eff   = new_frame ? 23'd0 : vin;
  assign base_row  = new_frame ? 11'd0 : out_row;
  assign base_col  = new_frame ? 11'd0 : out_col;
  assign past_lag  = (vin_eff >= {10'd0, lag});
  assign q         = vin_eff - {10'd0, lag};
  assign tail_done = past_lag && (q >= total);
  assign produce   = !drop && past_lag && !tail_done;
  assign last      = (q == total - 23'd1);

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      vin     <= 23'd0;
      out_row <= 11'd0;
      out_col <= 11'd0;
    end else if (req_acc && !drop) begin
      if (tail_done || (produce && last)) begin
        vin     <= 23'd0;
        out_row <= 11'd0;
        out_col <= 11'd0;
      end else begin
        vin     <= vin_eff + 23'd1;
        out_row <= base_row;
        out_col <= base_col;
        if (produce) begin
          if ({1'b0, base_col} + 12'd1 >= w_eff) begin
            out_col <= 11'd0;
            out_row <= base_row + 11'd1;
          end else begin
            out_col <= base_col + 11'd1;
          end
        end
      end
    end
  end

  // ---------------- pixel ring RAM ----------------
  logic [RAM_AW-1:0] tap_addr, ram_addr;
  logic              ram_we;
  logic [7:0]        ram_rdata;

  assign ram_we   = req_acc && !is_drain;
  assign ram_addr = (state == S_TAP) ? tap_addr : vin_eff[RAM_AW-1:0];

  icf_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req_item.pixel_in),
    .rdata (ram_rdata)
  );

  // ---------------- window walk ----------------
  logic [10:0]        job_row, job_col;
  logic               job_last;
  logic signed [12:0] pr, pc;
  logic [2:0]         wi, wj, w_lo, w_hi;
  logic               tap_end_col, tap_end_row;

  assign w_lo        = 3'd2 - {1'b0, rad};
  assign w_hi        = 3'd2 + {1'b0, rad};
  assign tap_end_col = (wj == w_hi);
  assign tap_end_row = (wi == w_hi);

  // read issued last cycle, data arrives now
  logic       pend_valid, pend_inb;
  logic [2:0] pend_wi, pend_wj;

  logic signed [19:0] accx, accy;
  logic signed [6:0]  wx, wy;
  logic signed [15:0] prodx, prody;
  logic signed [8:0]  pix9;
  logic [2:0]         sel_x;

  assign sel_x = (cfg_kernel == KSEL_MAG) ? KSEL_SOBELX : cfg_kernel;
  assign pix9  = {1'b0, ram_rdata};
  assign wx    = kern_weight(sel_x, pend_wi, pend_wj);
  assign wy    = kern_weight(KSEL_SOBELY, pend_wi, pend_wj);
  assign prodx = pend_inb ? (wx * pix9) : 16'sd0;
  assign prody = pend_inb ? (wy * pix9) : 16'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == S_TAP);
    end
  end

  // ---------------- post-processing datapath ----------------
  logic [16:0]        div_x;
  logic [37:0]        div_prod;
  logic [13:0]        div_q0;
  logic [23:0]        div_rem;
  logic [20:0]        sqx, sqy;
  logic [21:0]        rx, rm, rbit;
  logic signed [11:0] res_val, accx12, accy12;
  logic               is_blur;

  assign is_blur = (cfg_kernel == KSEL_BLUR3);
  assign accx12  = accx[11:0];
  assign accy12  = accy[11:0];
  assign div_q0  = div_prod[37:24];
  assign div_rem = {7'd0, div_x}
                 - 24'(div_q0 * (is_blur ? DIV_9 : DIV_273));

  always_ff @(posedge clk) begin
    if (req_acc && produce) begin
      job_row  <= base_row;
      job_col  <= base_col;
      job_last <= last;
      pr       <= $signed({2'b00, base_row}) - $signed({11'd0, rad});
      pc       <= $signed({2'b00, base_col}) - $signed({11'd0, rad});
      wi       <= w_lo;
      wj       <= w_lo;
      tap_addr <= q[RAM_AW-1:0] - RAM_AW'(lag);
      accx     <= 20'sd0;
      accy     <= 20'sd0;
    end else begin
      if (pend_valid) begin
        accx <= accx + {{4{prodx[15]}}, prodx};
        accy <= accy + {{4{prody[15]}}, prody};
      end
      if (state == S_TAP) begin
        pend_wi  <= wi;
        pend_wj  <= wj;
        pend_inb <= (pr >= 13'sd0) && (pc >= 13'sd0)
                 && (pr < $signed({1'b0, h_eff})) && (pc < $signed({1'b0, w_eff}));
        if (tap_end_col) begin
          wj       <= w_lo;
          wi       <= wi + 3'd1;
          pc       <= $signed({2'b00, job_col}) - $signed({11'd0, rad});
          pr       <= pr + 13'sd1;
          tap_addr <= tap_addr + row_skip;
        end else begin
          wj       <= wj + 3'd1;
          pc       <= pc + 13'sd1;
          tap_addr <= tap_addr + RAM_AW'(1);
        end
      end
    end

    case (state)
      S_TAIL: begin
        // plain kernels pass straight through; the final tap lands this cycle
        res_val <= accx12 + prodx[11:0];
      end
      S_DIV1: begin
        div_x    <= 17'(accx) + (is_blur ? 17'd4 : 17'd136);
        div_prod <= 38'((17'(accx) + (is_blur ? 17'd4 : 17'd136))
                        * (is_blur ? RECIP_9 : RECIP_273));
      end
      S_DIV2: begin
        res_val <= (div_rem >= {15'd0, (is_blur ? DIV_9 : DIV_273)})
                 ? 12'(div_q0 + 14'd1) : 12'(div_q0);
      end
      S_SQ: begin
        sqx <= 21'(accx12 * accx12);
        sqy <= 21'(accy12 * accy12);
      end
      S_SUM: begin
        rx   <= {1'b0, sqx} + {1'b0, sqy};
        rm   <= 22'd0;
        rbit <= 22'd1 << 20;
      end
      S_ROOT: begin
        if (rx >= rm + rbit) begin
          rx <= rx - (rm + rbit);
          rm <= (rm >> 1) + rbit;
        end else begin
          rm <= rm >> 1;
        end
        rbit <= rbit >> 2;
      end
      S_RND: begin
        res_val <= (rx > rm) ? 12'(rm + 22'd1) : 12'(rm);
      end
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  logic out_free;
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_acc && produce) state_next = S_TAP;
      S_TAP:  if (tap_end_col && tap_end_row) state_next = S_TAIL;
      S_TAIL: begin
        if (cfg_kernel == KSEL_BLUR3 || cfg_kernel == KSEL_GAUSS5) begin
          state_next = S_DIV1;
        end else if (cfg_kernel == KSEL_MAG) begin
          state_next = S_SQ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV1: state_next = S_DIV2;
      S_DIV2: state_next = S_FIN;
      S_SQ:   state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: if (rbit == 22'd1) state_next = S_RND;
      S_RND:  state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      res_item.filtered_value <= res_val;
      res_item.clamped_byte   <= res_val[11] ? 8'd0
                               : ((res_val > 12'sd255) ? 8'd255 : res_val[7:0]);
      res_item.out_row        <= job_row;
      res_item.out_col        <= job_col;
      res_item.frame_last     <= job_last;
    end
  end

  // ---------------- checks ----------------
  `ICF_ASSERT_SAME(a_ram_write_on_accept, clk, rst, ram_we, req_acc)
  `ICF_ASSERT_SAME(a_pend_in_walk, clk, rst, pend_valid, (state == S_TAP) || (state == S_TAIL))
  `ICF_ASSERT_NEXT(a_job_starts_walk, clk, rst, req_acc && produce, state == S_TAP)

endmodule

### dv/tb_top.sv
// Self-checking testbench for the streaming convolution filter unit.
`timescale 1ns / 1ps

module tb_top;
  import icf_pkg::*;

  // item type codes and the unused kernel code
  localparam logic       REQ_PIXEL = 1'b0;
  localparam logic       REQ_DRAIN = 1'b1;
  localparam logic [2:0] KSEL_NONE = 3'd7;

  // pixel history depth of the golden filter
  localparam int RING      = (K_MAX - 1) * W_MAX + 2 * K_MAX;
  // quiet cycles allowed before the run is declared hung
  localparam int QUIET_MAX = 4000;
  // settle time before a register write, covers the longest result pipeline
  localparam int SETTLE    = 64;
  localparam int HOLD_LEN  = 400;
  localparam int RAND_GOAL = 1650;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_DRAIN} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [11:0] reg_val;
    logic [7:0]  pixel;
    bit          typed;
    icf_res_t    want;
  } dir_row_t;

  typedef struct {
    icf_req_t it;
    bit       typed;
    icf_res_t want;
  } stim_t;

  logic        clk, rst;
  logic        req_valid, req_stall;
  icf_req_t    req_item;
  logic        res_valid, res_stall;
  icf_res_t    res_item;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  image_convolution_filter_unit uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Golden filter: own copy of geometry, kernel and pixel history
  // ---------------------------------------------------------------------------
  bit [7:0]    ring_mem [RING];
  int unsigned in_r, in_c, out_r, out_c;
  logic [11:0] cur_w, cur_h;
  logic [2:0]  cur_k;

  stim_t    stim_q[$];
  icf_res_t exp_q[$];
  int unsigned pushed_items, taken_items, results_seen, cfg_writes, fails;
  bit          long_hold;

  function automatic void frame_restart();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
  endfunction

  // 0 acts as 1, values past the maximum saturate
  function automatic int unsigned geo(input logic [11:0] x, input int unsigned lim);
    if (x == 0) return 1;
    return (x > lim) ? lim : x;
  endfunction

  function automatic void cfg_apply(input logic [1:0] idx, input logic [11:0] val);
    case (idx)
      REG_WIDTH:  cur_w = val;
      REG_HEIGHT: cur_h = val;
      REG_KERNEL: cur_k = val[2:0];
      default: return;
    endcase
    frame_restart();
  endfunction

  function automatic int pix_at(int row, int col, int unsigned w, int unsigned h);
    if (row < 0 || col < 0 || row >= int'(h) || col >= int'(w)) return 0;
    return int'(ring_mem[(int'(row) * w + col) % RING]);
  endfunction

  function automatic int kern_sum(int sel, int row, int col, int unsigned w, int unsigned h);
    int s;
    s = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        s += int'(KERN_TAB[sel][i * 5 + j]) * pix_at(row + i - 2, col + j - 2, w, h);
    return s;
  endfunction

  // nearest integer square root, halves go up
  function automatic int round_root(int unsigned n);
    int unsigned m;
    m = 0;
    while ((m + 1) * (m + 1) <= n) m++;
    if (n > m * m + m) m++;
    return int'(m);
  endfunction

  function automatic int conv_value(int row, int col, int unsigned w, int unsigned h);
    int gx, gy;
    case (cur_k)
      KSEL_BLUR3:  return (kern_sum(0, row, col, w, h) + 4) / 9;
      KSEL_GAUSS5: return (kern_sum(1, row, col, w, h) + 136) / 273;
      KSEL_SOBELX, KSEL_SOBELY, KSEL_SHARPEN, KSEL_EMBOSS:
        return kern_sum(int'(cur_k), row, col, w, h);
      KSEL_MAG: begin
        gx = kern_sum(int'(KSEL_SOBELX), row, col, w, h);
        gy = kern_sum(int'(KSEL_SOBELY), row, col, w, h);
        return round_root(int'(gx * gx + gy * gy));
      end
      default: return 0;
    endcase
  endfunction

  // one accepted item; returns 1 when it releases an output pixel
  function automatic bit conv_step(input icf_req_t it, output icf_res_t r);
    int unsigned w, h, rad, lag, total, vin, q;
    int v;
    w = geo(cur_w, W_MAX);
    h = geo(cur_h, H_MAX);
    rad = (cur_k == KSEL_GAUSS5) ? 2 : 1;
    lag = rad * w + rad;
    total = w * h;
    vin = in_r * w + in_c;
    r = '0;
    if (it.req_type == REQ_PIXEL) begin
      // a pixel past a finished frame starts the next one
      if (vin >= total) begin
        frame_restart();
        vin = 0;
      end
      ring_mem[vin % RING] = it.pixel_in;
    end else if (vin < total) begin
      return 0;  // drain before the frame is complete
    end
    in_c++;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
    end
    if (vin < lag) return 0;
    q = vin - lag;
    if (q >= total) begin
      frame_restart();
      return 0;
    end
    v = conv_value(out_r, out_c, w, h);
    r.filtered_value = v[11:0];
    r.clamped_byte   = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
    r.out_row        = out_r[10:0];
    r.out_col        = out_c[10:0];
    r.frame_last     = (q == total - 1);
    if (r.frame_last) begin
      frame_restart();
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of items with random gaps; prediction happens on acceptance
  // ---------------------------------------------------------------------------
  initial begin : sender
    stim_t       cur;
    icf_res_t    pred;
    bit          took;
    int unsigned burst_left, gap_left;
    req_valid = 1'b0;
    req_item = '0;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      took = !rst && req_valid && !req_stall;
      if (took) begin
        if (conv_step(cur.it, pred) || cur.typed)
          exp_q.push_back(cur.typed ? cur.want : pred);
        taken_items++;
        if (burst_left > 0) burst_left--;
      end
      @(negedge clk);
      if (took || !req_valid) begin
        if (burst_left == 0) begin
          // one burst in four on average is long with no gap so the pipe runs back to back
          if ($urandom_range(3) == 0) begin
            burst_left = $urandom_range(200, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(30, 1);
            gap_left = $urandom_range(12);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
          req_valid = 1'b0;
        end else if (stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          req_item = cur.it;
          req_valid = 1'b1;
        end else begin
          req_valid = 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall modes that change at random, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode, mode_left;
    res_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        // hold off long enough that the block backs up onto its input
        res_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3);
          mode_left = $urandom_range(80, 5);
        end
        mode_left--;
        case (mode)
          0: res_stall = 1'b0;
          1: res_stall = $urandom_range(1);
          2: res_stall = ($urandom_range(7) != 0);
          default: res_stall = ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  icf_res_t    want_res;
  bit          bad;
  int unsigned quiet;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected result item: expected none, got %p", $time, res_item);
        fails++;
      end else begin
        want_res = exp_q.pop_front();
        results_seen++;
        bad = 1'b0;
        if (res_item.filtered_value !== want_res.filtered_value) begin
          $display("%0t filtered_value: expected %0d, got %0d", $time,
                   want_res.filtered_value, res_item.filtered_value);
          bad = 1'b1;
        end
        if (res_item.clamped_byte !== want_res.clamped_byte) begin
          $display("%0t clamped_byte: expected %0d, got %0d", $time,
                   want_res.clamped_byte, res_item.clamped_byte);
          bad = 1'b1;
        end
        if (res_item.out_row !== want_res.out_row) begin
          $display("%0t out_row: expected %0d, got %0d", $time,
                   want_res.out_row, res_item.out_row);
          bad = 1'b1;
        end
        if (res_item.out_col !== want_res.out_col) begin
          $display("%0t out_col: expected %0d, got %0d", $time,
                   want_res.out_col, res_item.out_col);
          bad = 1'b1;
        end
        if (res_item.frame_last !== want_res.frame_last) begin
          $display("%0t frame_last: expected %0d, got %0d", $time,
                   want_res.frame_last, res_item.frame_last);
          bad = 1'b1;
        end
        if (bad) fails++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, QUIET_MAX);
      $display("image_convolution_filter_unit test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic rt, input logic [7:0] px);
    stim_t s;
    s.it.req_type = rt;
    s.it.pixel_in = px;
    s.typed = 1'b0;
    s.want = '0;
    stim_q.push_back(s);
    pushed_items++;
  endtask

  // all items taken, all results back, then let the pipeline settle
  task automatic wait_idle();
    while (stim_q.size() != 0 || taken_items != pushed_items || exp_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {20'd0, val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cfg_apply(idx, val);
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [11:0] w, input logic [11:0] h,
                              input logic [2:0] k);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_KERNEL, k);
  endtask

  // one frame of pixels and its flush; style picks clean, noisy or cut short
  task automatic push_frame(input int unsigned npix, input int unsigned lag,
                            output int unsigned count);
    int unsigned style, vmode, ndrain;
    logic [7:0]  px;
    style = $urandom_range(7);
    vmode = $urandom_range(3);
    count = 0;
    for (int unsigned p = 0; p < npix; p++) begin
      case (vmode)
        0: px = $urandom_range(1) ? 8'hFF : 8'h00;
        1: px = $urandom_range(255, 200);
        default: px = $urandom;
      endcase
      push_item(REQ_PIXEL, px);
      count++;
      // early drains in the middle of the frame are ignored
      if (style == 0 && $urandom_range(9) == 0) push_item(REQ_DRAIN, $urandom);
    end
    ndrain = lag + $urandom_range(2);
    // cut the flush short so the next pixel abandons the tail
    if (style == 1) ndrain = $urandom_range(lag);
    for (int unsigned d = 0; d < ndrain; d++) begin
      push_item(REQ_DRAIN, $urandom);
      count++;
    end
  endtask

  // directed table; typed expectations are the ones readable at a glance
  localparam int NDIR = 56;
  dir_row_t dir_tab [NDIR] = '{
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h5A, 1'b0, '0},  // reset geometry, no result yet
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},  // drain before the frame is full
    '{ROW_CFG,   REG_WIDTH,  12'd1,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_HEIGHT, 12'd1,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_BLUR3}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b1, '{12'sd28, 8'd28, 11'd0, 11'd0, 1'b1}},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},  // after frame end: ignored
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_SHARPEN}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b1, '{12'sd1275, 8'd255, 11'd0, 11'd0, 1'b1}},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_SOBELX}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b1, '{12'sd0, 8'd0, 11'd0, 11'd0, 1'b1}},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_GAUSS5}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b1, '{12'sd38, 8'd38, 11'd0, 11'd0, 1'b1}},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_NONE}, 8'h00, 1'b0, '0},  // unused code
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hAA, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b1, '{12'sd0, 8'd0, 11'd0, 11'd0, 1'b1}},
    '{ROW_CFG,   REG_WIDTH,  12'd2,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_HEIGHT, 12'd2,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_EMBOSS}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h80, 1'b0, '0},  // pixel while the tail is pending
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h01, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFE, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h7F, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_SOBELY}, 8'h00, 1'b0, '0},  // negative values
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_CFG,   REG_KERNEL, {9'd0, KSEL_MAG}, 8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'hFF, 1'b0, '0},
    '{ROW_PIX,   REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0},
    '{ROW_DRAIN, REG_WIDTH,  12'd0,  8'h00, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_t       s;
    int unsigned rand_items, phase, nf, got, w, h, lag;
    logic [11:0] wv, hv;
    logic [2:0]  kv;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_hold = 1'b0;
    cur_w = 12'd1024;
    cur_h = 12'd1024;
    cur_k = KSEL_BLUR3;
    frame_restart();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        s.it.req_type = (dir_tab[i].kind == ROW_DRAIN) ? REQ_DRAIN : REQ_PIXEL;
        s.it.pixel_in = dir_tab[i].pixel;
        s.typed = dir_tab[i].typed;
        s.want = dir_tab[i].want;
        stim_q.push_back(s);
        pushed_items++;
      end
    end
    // flush the last directed frame
    push_item(REQ_DRAIN, 8'h00);

    // extreme geometries, one frame each (the last one only partly sent)
    set_geometry(12'd4095, 12'd1, KSEL_MAG);      // width saturates
    push_frame(W_MAX, W_MAX + 1, got);
    set_geometry(12'd1, 12'd2048, KSEL_GAUSS5);   // tallest frame, narrowest line
    push_frame(H_MAX, 4, got);
    set_geometry(12'd0, 12'd0, KSEL_SOBELY);      // zero acts as one
    push_frame(1, 2, got);
    set_geometry(12'd2048, 12'd4095, KSEL_EMBOSS);
    for (int unsigned p = 0; p < 2 * W_MAX + 64; p++) push_item(REQ_PIXEL, $urandom);

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_GOAL) begin
      wv = ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      hv = $urandom_range(6, 1);
      kv = $urandom_range(7);
      set_geometry(wv, hv, kv);
      w = geo(wv, W_MAX);
      h = geo(hv, H_MAX);
      lag = ((kv == KSEL_GAUSS5) ? 2 : 1) * (w + 1);
      nf = $urandom_range(3, 1);
      for (int unsigned f = 0; f < nf; f++) begin
        push_frame(w * h, lag, got);
        rand_items += got;
      end
      if (phase == 3) long_hold = 1'b1;
      phase++;
    end

    wait_idle();
    $display("covered %0d items, %0d results, %0d register writes", taken_items,
             results_seen, cfg_writes);
    $display("all kernels, extreme and saturated geometry, early drain, cut flushes");
    if (fails == 0 && exp_q.size() == 0) begin
      $display("image_convolution_filter_unit test passed");
    end else begin
      $display("image_convolution_filter_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/icf_pkg.sv
design/icf_ram.sv
design/image_convolution_filter_unit.sv
dv/tb_top.sv
